/* rtl/core/timed_nudge_setpoint_sequencer_defines.svh */
// Assertion macros used by the checker file of the setpoint sequencer.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef TIMED_NUDGE_SETPOINT_SEQUENCER_DEFINES_SVH
`define TIMED_NUDGE_SETPOINT_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TNSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TNSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tnss_pkg.sv */
// Shared constants and types of the timed nudge setpoint sequencer.
// No dependencies; used by every module of the block.
package tnss_pkg;

    // command codes carried in s_tuser
    localparam logic [2:0] FUNC_UPDATE    = 3'd0;
    localparam logic [2:0] FUNC_FWD       = 3'd1;
    localparam logic [2:0] FUNC_BWD       = 3'd2;
    localparam logic [2:0] FUNC_STOP_MOVE = 3'd3;
    localparam logic [2:0] FUNC_LEFT      = 3'd4;
    localparam logic [2:0] FUNC_RIGHT     = 3'd5;
    localparam logic [2:0] FUNC_STOP_TURN = 3'd6;

    // movement phases
    localparam logic [2:0] PH_NONE     = 3'd0;
    localparam logic [2:0] PH_FWD      = 3'd1;
    localparam logic [2:0] PH_BWD      = 3'd2;
    localparam logic [2:0] PH_RET_FWD  = 3'd3;
    localparam logic [2:0] PH_RET_BWD  = 3'd4;
    localparam logic [2:0] PH_HOLD_FWD = 3'd5;
    localparam logic [2:0] PH_HOLD_BWD = 3'd6;

    // turn directions
    localparam logic [1:0] TURN_NONE  = 2'd0;
    localparam logic [1:0] TURN_LEFT  = 2'd1;
    localparam logic [1:0] TURN_RIGHT = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_MOVE_OFFSET = 3'd0;
    localparam logic [2:0] CFG_HOLD_OFFSET = 3'd1;
    localparam logic [2:0] CFG_TURN_BOOST  = 3'd2;
    localparam logic [2:0] CFG_MOVE_MS     = 3'd3;
    localparam logic [2:0] CFG_RETURN_MS   = 3'd4;
    localparam logic [2:0] CFG_TURN_MS     = 3'd5;

    // port widths and layout
    localparam int IN_TDATA_W    = 80;
    localparam int IN_TUSER_W    = 3;
    localparam int OUT_TDATA_W   = 72;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 31;
    localparam int OUT_MOVING_BIT = 64;
    localparam int OUT_PHASE_LSB = 66;

    // ramp fraction: Q1.16, up to and including 1.0
    localparam int Q_W = 17;

    // drive adjust request
    typedef struct packed {
        logic [1:0]         turn_dir;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } drive_in_t;

endpackage

/* rtl/core/tnss_div.sv */
// Iterative restoring divider for the ramp fraction: quot = floor(num*2^16/den).
// One quotient bit per cycle; requires num <= den and den != 0. Uses tnss_pkg.
module tnss_div #(
    parameter int W = 36
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start_i,
    input  logic [W-1:0]               num_i,
    input  logic [W-1:0]               den_i,
    output logic                       done_o,
    output logic [tnss_pkg::Q_W-1:0]   quot_o
);
    import tnss_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic             busy_reg;
    logic             first_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W:0]       rem_reg;
    logic [W-1:0]     den_reg;
    logic [Q_W-1:0]   quot_reg;

    logic [W:0] trial;
    logic       ge;
    logic [W:0] rem_next;

    // one shift / compare / subtract step
    always_comb begin
        trial    = first_reg ? rem_reg : {rem_reg[W-1:0], 1'b0};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? trial - {1'b0, den_reg} : trial;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start_i) begin
            rem_reg   <= {1'b0, num_i};
            den_reg   <= den_i;
            first_reg <= 1'b1;
            quot_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg   <= rem_next;
            first_reg <= 1'b0;
            quot_reg  <= {quot_reg[Q_W-2:0], ge};
        end
    end

    assign done_o = done_reg;
    assign quot_o = quot_reg;

endmodule

/* rtl/core/tnss_drive.sv */
// Turn adjustment of the two drives: add / subtract the boost, clamp to +-100.0.
// Passes the drives through when no turn is active. Uses tnss_pkg.
module tnss_drive #(
    parameter int DRIVE_FRAC_BITS = 8,
    parameter int BOOST_W         = 15
) (
    input  tnss_pkg::drive_in_t  drv_i,
    input  logic [BOOST_W-1:0]   boost_i,
    output logic signed [15:0]   left_o,
    output logic signed [15:0]   right_o
);
    import tnss_pkg::*;

    localparam int LIM  = 100 << DRIVE_FRAC_BITS;
    localparam int HI_I = (LIM > 32767) ? 32767 : LIM;
    localparam int LO_I = (LIM > 32768) ? -32768 : -LIM;
    localparam logic signed [17:0] HI = 18'(HI_I);
    localparam logic signed [17:0] LO = 18'(LO_I);

    logic [16:0]        b_eff;
    logic signed [17:0] b_s;
    logic signed [17:0] l_w;
    logic signed [17:0] r_w;
    logic signed [17:0] l_adj;
    logic signed [17:0] r_adj;

    // boost capped at the drive limit
    always_comb begin
        b_eff = (32'(boost_i) > LIM) ? 17'(LIM) : 17'(boost_i);
        b_s   = $signed({1'b0, b_eff});
        l_w   = 18'(drv_i.left);
        r_w   = 18'(drv_i.right);
    end

    // differential add, then clamp
    always_comb begin
        l_adj = l_w;
        r_adj = r_w;
        if (drv_i.turn_dir == TURN_LEFT) begin
            l_adj = l_w - b_s;
            r_adj = r_w + b_s;
        end else if (drv_i.turn_dir == TURN_RIGHT) begin
            l_adj = l_w + b_s;
            r_adj = r_w - b_s;
        end
        if (l_adj > HI) l_adj = HI;
        if (l_adj < LO) l_adj = LO;
        if (r_adj > HI) r_adj = HI;
        if (r_adj < LO) r_adj = LO;
        if (drv_i.turn_dir == TURN_NONE) begin
            left_o  = drv_i.left;
            right_o = drv_i.right;
        end else begin
            left_o  = l_adj[15:0];
            right_o = r_adj[15:0];
        end
    end

endmodule

/* rtl/core/timed_nudge_setpoint_sequencer.sv */
// Timed nudge setpoint sequencer, top level.
// Depends on tnss_pkg, tnss_div and tnss_drive.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready with the command code in s_tuser and
//   advance_us, setpoint_in, left_drive_in, right_drive_in in s_tdata. Each item
//   gives exactly one result item on m_tvalid/m_tready.
//   Registers are written through cfg_wr_en/cfg_addr/cfg_wdata while idle.
// Processing:
//   A command passes the advance and finish states; an update also passes the
//   update and offset states and, in a return phase, the divider, which gives the
//   ramp fraction at one bit per cycle (17 steps) before one multiply and the ramp
//   step; a zero return span skips the divider. One item in work at a time.
// Reset:
//   aresetn (synchronous, active low) clears the phase, turn, timers and output
//   valid and loads the documented register defaults.
// Stall:
//   The result sits in an output register; a new item may be accepted while it
//   waits. A finished item then waits until the output register frees up.
module timed_nudge_setpoint_sequencer #(
    parameter int SETPOINT_FRAC_BITS = 16,
    parameter int DRIVE_FRAC_BITS    = 8,
    parameter int US_PER_MS          = 1000
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] advance_us, [47:16] setpoint_in, [63:48] left_drive_in,
    // [79:64] right_drive_in
    input  logic [tnss_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [2:0] func
    input  logic [tnss_pkg::IN_TUSER_W-1:0]     s_tuser,
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] active_setpoint, [47:32] left_drive_out, [63:48] right_drive_out,
    // [64] moving, [65] rotating, [68:66] phase_out, [71:69] zero
    output logic [tnss_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [tnss_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tnss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import tnss_pkg::*;

    localparam int US_W      = $clog2(US_PER_MS + 1);
    localparam int THR_W     = 16 + US_W;
    localparam logic [US_W-1:0] US_K = US_W'(US_PER_MS);
    localparam int MOVE_RST  = 1 << SETPOINT_FRAC_BITS;
    localparam int HOLD_RST  = ((1 << SETPOINT_FRAC_BITS) + 5) / 10;
    localparam int BOOST_RST = 10 << DRIVE_FRAC_BITS;
    localparam int BOOST_W   = ($clog2(BOOST_RST + 1) > 15) ? $clog2(BOOST_RST + 1) : 15;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADV  = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_RAMP = 3'd5;
    localparam logic [2:0] ST_OFS  = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    // configuration registers
    logic [30:0]        move_offset_reg;
    logic [30:0]        hold_offset_reg;
    logic [BOOST_W-1:0] turn_boost_reg;
    logic [15:0]        move_ms_reg;
    logic [15:0]        return_ms_reg;
    logic [15:0]        turn_ms_reg;

    // derived from configuration
    logic [THR_W-1:0]   thr_move_reg;
    logic [THR_W-1:0]   thr_ret_reg;
    logic [THR_W-1:0]   thr_turn_reg;
    logic signed [31:0] diff_reg;

    // sequencer state
    logic [2:0]  st_reg;
    logic [2:0]  st_next;
    logic [2:0]  phase_reg;
    logic [1:0]  turn_reg;
    logic [31:0] move_el_reg;
    logic [31:0] turn_el_reg;

    // item in work
    logic [2:0]         func_reg;
    logic [15:0]        adv_reg;
    logic signed [31:0] sp_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;

    // arithmetic pipeline
    logic [Q_W-1:0]     q_reg;
    logic signed [49:0] prod_reg;
    logic signed [31:0] ramp_reg;
    logic signed [31:0] off_reg;

    // output register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // config write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_offset_reg <= 31'(MOVE_RST);
            hold_offset_reg <= 31'(HOLD_RST);
            turn_boost_reg  <= BOOST_W'(BOOST_RST);
            move_ms_reg     <= 16'd500;
            return_ms_reg   <= 16'd800;
            turn_ms_reg     <= 16'd1000;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MOVE_OFFSET: move_offset_reg <= cfg_wdata;
                CFG_HOLD_OFFSET: hold_offset_reg <= cfg_wdata;
                CFG_TURN_BOOST:  turn_boost_reg  <= BOOST_W'(cfg_wdata[14:0]);
                CFG_MOVE_MS:     move_ms_reg     <= cfg_wdata[15:0];
                CFG_RETURN_MS:   return_ms_reg   <= cfg_wdata[15:0];
                CFG_TURN_MS:     turn_ms_reg     <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // thresholds in us and ramp span, refreshed every cycle
    always_ff @(posedge aclk) begin
        thr_move_reg <= THR_W'(move_ms_reg) * THR_W'(US_K);
        thr_ret_reg  <= THR_W'(return_ms_reg) * THR_W'(US_K);
        thr_turn_reg <= THR_W'(turn_ms_reg) * THR_W'(US_K);
        diff_reg     <= $signed({1'b0, move_offset_reg}) - $signed({1'b0, hold_offset_reg});
    end

    // saturating timer advance
    logic [32:0] me_sum;
    logic [32:0] te_sum;
    logic [31:0] me_adv;
    logic [31:0] te_adv;

    always_comb begin
        me_sum = {1'b0, move_el_reg} + 33'(adv_reg);
        te_sum = {1'b0, turn_el_reg} + 33'(adv_reg);
        me_adv = me_sum[32] ? '1 : me_sum[31:0];
        te_adv = te_sum[32] ? '1 : te_sum[31:0];
    end

    // expiry check of an update
    logic [2:0]       ph_upd;
    logic [31:0]      me_upd;
    logic [1:0]       turn_upd;
    logic             ramp_div;
    logic [THR_W-1:0] div_num;

    always_comb begin
        ph_upd   = phase_reg;
        me_upd   = move_el_reg;
        turn_upd = turn_reg;
        unique case (phase_reg)
            PH_FWD, PH_BWD: begin
                if (64'(move_el_reg) >= 64'(thr_move_reg)) begin
                    ph_upd = (phase_reg == PH_FWD) ? PH_RET_FWD : PH_RET_BWD;
                    me_upd = '0;
                end
            end
            PH_RET_FWD, PH_RET_BWD: begin
                if (64'(move_el_reg) >= 64'(thr_ret_reg))
                    ph_upd = (phase_reg == PH_RET_FWD) ? PH_HOLD_FWD : PH_HOLD_BWD;
            end
            default: ;
        endcase
        if (turn_reg != TURN_NONE && 64'(turn_el_reg) >= 64'(thr_turn_reg))
            turn_upd = TURN_NONE;
        ramp_div = (ph_upd == PH_RET_FWD || ph_upd == PH_RET_BWD) &&
                   (thr_ret_reg != '0) && (64'(me_upd) < 64'(thr_ret_reg));
        div_num  = thr_ret_reg - THR_W'(me_upd);
    end

    // divider for the ramp fraction
    logic           div_start;
    logic           div_done;
    logic [Q_W-1:0] div_q;

    assign div_start = (st_reg == ST_UPD) && ramp_div;

    tnss_div #(
        .W (THR_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (div_start),
        .num_i   (div_num),
        .den_i   (thr_ret_reg),
        .done_o  (div_done),
        .quot_o  (div_q)
    );

    // ramp offset: hold + trunc(diff * q / 2^16)
    logic signed [49:0] prod_adj;
    logic signed [49:0] prod_shr;
    logic signed [32:0] ramp_sum;

    always_comb begin
        prod_adj = prod_reg + (prod_reg[49] ? 50'sd65535 : 50'sd0);
        prod_shr = prod_adj >>> 16;
        ramp_sum = $signed({2'b00, hold_offset_reg}) +
                   $signed({prod_shr[31], prod_shr[31:0]});
    end

    // result assembly
    logic                  upd_item;
    logic                  out_free;
    logic signed [32:0]    sp_sum;
    logic signed [31:0]    sp_res;
    drive_in_t             drv_req;
    logic signed [15:0]    left_res;
    logic signed [15:0]    right_res;

    always_comb begin
        upd_item = (func_reg == FUNC_UPDATE);
        out_free = !m_tvalid_reg || m_tready;
        sp_sum   = {sp_reg[31], sp_reg} + {off_reg[31], off_reg};
        if (!upd_item)
            sp_res = sp_reg;
        else if (sp_sum[32] != sp_sum[31])
            sp_res = sp_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            sp_res = sp_sum[31:0];
        drv_req.turn_dir = upd_item ? turn_reg : TURN_NONE;
        drv_req.left     = left_reg;
        drv_req.right    = right_reg;
    end

    tnss_drive #(
        .DRIVE_FRAC_BITS (DRIVE_FRAC_BITS),
        .BOOST_W         (BOOST_W)
    ) u_drive (
        .drv_i   (drv_req),
        .boost_i (turn_boost_reg),
        .left_o  (left_res),
        .right_o (right_res)
    );

    // sequencer next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (s_tvalid) st_next = ST_ADV;
            ST_ADV:  st_next = (func_reg == FUNC_UPDATE) ? ST_UPD : ST_FIN;
            ST_UPD: begin
                if (ramp_div)
                    st_next = ST_DIV;
                else if (ph_upd == PH_RET_FWD || ph_upd == PH_RET_BWD)
                    st_next = ST_MUL;
                else
                    st_next = ST_OFS;
            end
            ST_DIV:  if (div_done) st_next = ST_MUL;
            ST_MUL:  st_next = ST_RAMP;
            ST_RAMP: st_next = ST_OFS;
            ST_OFS:  st_next = ST_FIN;
            ST_FIN:  if (out_free) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    // sequencer and timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            phase_reg   <= PH_NONE;
            turn_reg    <= TURN_NONE;
            move_el_reg <= '0;
            turn_el_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (st_reg == ST_ADV) begin
                move_el_reg <= me_adv;
                turn_el_reg <= te_adv;
                unique case (func_reg)
                    FUNC_FWD, FUNC_BWD: begin
                        phase_reg   <= (func_reg == FUNC_FWD) ? PH_FWD : PH_BWD;
                        move_el_reg <= '0;
                    end
                    FUNC_STOP_MOVE: phase_reg <= PH_NONE;
                    FUNC_LEFT, FUNC_RIGHT: begin
                        turn_reg    <= (func_reg == FUNC_LEFT) ? TURN_LEFT : TURN_RIGHT;
                        turn_el_reg <= '0;
                    end
                    FUNC_STOP_TURN: turn_reg <= TURN_NONE;
                    default: ;
                endcase
            end else if (st_reg == ST_UPD) begin
                phase_reg   <= ph_upd;
                move_el_reg <= me_upd;
                turn_reg    <= turn_upd;
            end
        end
    end

    // item capture and arithmetic steps
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg  <= s_tuser[2:0];
            adv_reg   <= s_tdata[15:0];
            sp_reg    <= s_tdata[47:16];
            left_reg  <= s_tdata[63:48];
            right_reg <= s_tdata[79:64];
        end
        if (st_reg == ST_UPD && !ramp_div)
            q_reg <= '0;
        else if (st_reg == ST_DIV && div_done)
            q_reg <= div_q;
        if (st_reg == ST_MUL)
            prod_reg <= diff_reg * $signed({1'b0, q_reg});
        if (st_reg == ST_RAMP)
            ramp_reg <= ramp_sum[31:0];
        if (st_reg == ST_OFS) begin
            unique case (phase_reg)
                PH_FWD:      off_reg <= -$signed({1'b0, move_offset_reg});
                PH_BWD:      off_reg <= $signed({1'b0, move_offset_reg});
                PH_RET_FWD:  off_reg <= -ramp_reg;
                PH_RET_BWD:  off_reg <= ramp_reg;
                PH_HOLD_FWD: off_reg <= -$signed({1'b0, hold_offset_reg});
                PH_HOLD_BWD: off_reg <= $signed({1'b0, hold_offset_reg});
                default:     off_reg <= '0;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (st_reg == ST_FIN && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_FIN && out_free)
            m_tdata_reg <= {3'b000, phase_reg, (turn_reg != TURN_NONE),
                            (phase_reg != PH_NONE), right_res, left_res, sp_res};
    end

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/core/tnss_checker.sv */
// Port-level checks of the timed nudge setpoint sequencer, bound to the top.
// Depends on tnss_pkg and timed_nudge_setpoint_sequencer_defines.svh.
`include "timed_nudge_setpoint_sequencer_defines.svh"

module tnss_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tnss_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tnss_pkg::*;

    // stalled result keeps its valid and its data
    `TNSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed or dropped under stall")

    // one item in work at a time
    `TNSS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while one is in work")

    // padding above the fields stays zero
    `TNSS_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[OUT_TDATA_W-1:OUT_PHASE_LSB+3] == 3'b000, "nonzero padding in result item")

    // moving flag agrees with the reported phase
    `TNSS_ASSERT_NOW(a_moving, m_tvalid, m_tdata[OUT_MOVING_BIT] == (m_tdata[OUT_PHASE_LSB+2:OUT_PHASE_LSB] != PH_NONE), "moving flag disagrees with phase")

endmodule

bind timed_nudge_setpoint_sequencer tnss_checker u_tnss_checker (.*);
